@@ sv/cau_pkg.sv @@
// shared types and constants for the complex arithmetic unit
// no dependencies; imported by every module of the block
`default_nettype none
package cau_pkg;

   localparam int DataW       = 32;
   localparam int ProdW       = 64;
   localparam int QFrac       = 16;
   localparam int DivSteps    = ProdW + QFrac;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // classified work item passed from front to back
   typedef struct packed {
      op_type             op;
      logic [DataW-1:0]   fast_re;
      logic [DataW-1:0]   fast_im;
      logic               fast_ov;
      logic               dz;
      logic [ProdW-1:0]   den;
      logic [ProdW-1:0]   mag_re;
      logic [ProdW-1:0]   mag_im;
      logic               neg_re;
      logic               neg_im;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

@@ sv/cau_front.sv @@
// front end: accepts operand transactions, forms products, sums and divide operands
// depends on cau_pkg
`default_nettype none
module cau_front import cau_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [4*DataW-1:0] req_tdata,
   input  wire logic [1:0]         req_tuser,
   output logic                    push,
   output item_type                push_item,
   input  wire qstat_type          q_stat
);

   logic en;
   logic a_vld_ff, b_vld_ff, c_vld_ff;
   op_type a_op_ff, b_op_ff;
   logic signed [DataW-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [ProdW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_br_ff, p_bi_ff;
   logic signed [ProdW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_br_in, p_bi_in;
   logic signed [DataW:0]   s_re_ff, s_im_ff, s_re_in, s_im_in;
   item_type c_ff, c_in;
   logic signed [ProdW:0]   m_re, m_im;
   logic [DataW:0] sat_re, sat_im;

   function automatic logic [DataW:0] sat65(input logic signed [ProdW:0] v);
      logic [DataW:0] r;
      if (v > 65'sd2147483647)       r = {1'b1, 32'h7fff_ffff};
      else if (v < -65'sd2147483648) r = {1'b1, 32'h8000_0000};
      else                           r = {1'b0, v[DataW-1:0]};
      return r;
   endfunction

   assign en         = !q_stat.full;
   assign req_tready = en;
   assign push       = en && c_vld_ff;
   assign push_item  = c_ff;

   // stage b: six products and the add/sub sums
   always_comb begin
      p_rr_in = a_re_ff * b_re_ff;
      p_ii_in = a_im_ff * b_im_ff;
      p_ri_in = a_re_ff * b_im_ff;
      p_ir_in = a_im_ff * b_re_ff;
      p_br_in = b_re_ff * b_re_ff;
      p_bi_in = b_im_ff * b_im_ff;
      if (a_op_ff == OP_SUB) begin
         s_re_in = {a_re_ff[DataW-1], a_re_ff} - {b_re_ff[DataW-1], b_re_ff};
         s_im_in = {a_im_ff[DataW-1], a_im_ff} - {b_im_ff[DataW-1], b_im_ff};
      end else begin
         s_re_in = {a_re_ff[DataW-1], a_re_ff} + {b_re_ff[DataW-1], b_re_ff};
         s_im_in = {a_im_ff[DataW-1], a_im_ff} + {b_im_ff[DataW-1], b_im_ff};
      end
   end

   // stage c: combine products, saturate fast results, build divide operands
   always_comb begin
      if (b_op_ff == OP_MUL) begin
         m_re = {p_rr_ff[ProdW-1], p_rr_ff} - {p_ii_ff[ProdW-1], p_ii_ff};
         m_im = {p_ri_ff[ProdW-1], p_ri_ff} + {p_ir_ff[ProdW-1], p_ir_ff};
      end else begin
         m_re = {p_rr_ff[ProdW-1], p_rr_ff} + {p_ii_ff[ProdW-1], p_ii_ff};
         m_im = {p_ir_ff[ProdW-1], p_ir_ff} - {p_ri_ff[ProdW-1], p_ri_ff};
      end
      if (b_op_ff == OP_MUL) begin
         sat_re = sat65(m_re >>> QFrac);
         sat_im = sat65(m_im >>> QFrac);
      end else begin
         sat_re = sat65({{(ProdW-DataW){s_re_ff[DataW]}}, s_re_ff});
         sat_im = sat65({{(ProdW-DataW){s_im_ff[DataW]}}, s_im_ff});
      end
      c_in.op      = b_op_ff;
      c_in.fast_re = sat_re[DataW-1:0];
      c_in.fast_im = sat_im[DataW-1:0];
      c_in.fast_ov = sat_re[DataW] | sat_im[DataW];
      c_in.den     = p_br_ff + p_bi_ff;
      c_in.dz      = (c_in.den == '0);
      c_in.neg_re  = m_re[ProdW];
      c_in.neg_im  = m_im[ProdW];
      c_in.mag_re  = m_re[ProdW] ? 64'(-m_re) : m_re[ProdW-1:0];
      c_in.mag_im  = m_im[ProdW] ? 64'(-m_im) : m_im[ProdW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff <= op_type'(req_tuser);
         a_re_ff <= req_tdata[DataW-1:0];
         a_im_ff <= req_tdata[2*DataW-1:DataW];
         b_re_ff <= req_tdata[3*DataW-1:2*DataW];
         b_im_ff <= req_tdata[4*DataW-1:3*DataW];
         b_op_ff <= a_op_ff;
         p_rr_ff <= p_rr_in;
         p_ii_ff <= p_ii_in;
         p_ri_ff <= p_ri_in;
         p_ir_ff <= p_ir_in;
         p_br_ff <= p_br_in;
         p_bi_ff <= p_bi_in;
         s_re_ff <= s_re_in;
         s_im_ff <= s_im_in;
         c_ff    <= c_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/cau_queue.sv @@
// small decoupling fifo between front and back of the complex arithmetic unit
// depends on cau_pkg
`default_nettype none
module cau_queue import cau_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire item_type  push_item,
   input  wire logic      pop,
   output item_type       pop_item,
   output qstat_type      q_stat
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   item_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == CW'(Depth));
   assign q_stat.empty = (cnt_ff == '0);
   assign pop_item     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule
`default_nettype wire

@@ sv/cau_back.sv @@
// back end: pipelined restoring divider, result selection and output register
// depends on cau_pkg
`default_nettype none
module cau_back import cau_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   output logic                   pop,
   input  wire item_type          pop_item,
   input  wire qstat_type         q_stat,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [2*DataW-1:0]     rsp_tdata,
   output logic [1:0]             rsp_tuser
);

   typedef struct packed {
      item_type          it;
      logic [ProdW-1:0]  rem_re;
      logic [ProdW-1:0]  rem_im;
      logic [DataW:0]    q_re;
      logic [DataW:0]    q_im;
      logic              big_re;
      logic              big_im;
   } dstage_type;

   logic en;
   logic [DivSteps:0] vld_ff;
   dstage_type stg_ff [DivSteps+1];
   dstage_type stg_in [DivSteps+1];
   logic out_vld_ff;
   logic [DataW-1:0] out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic out_ov_ff, out_dz_ff, out_ov_in, out_dz_in;
   logic [DataW:0] fin_re, fin_im;

   // one restoring step: shift in a numerator bit, subtract when it fits
   function automatic logic [ProdW:0] div_step(input logic [ProdW-1:0] rem,
                                               input logic nb,
                                               input logic [ProdW-1:0] den);
      logic [ProdW:0] t;
      logic [ProdW:0] r;
      t = {rem, nb};
      if (t >= {1'b0, den}) r = {1'b1, 64'(t - {1'b0, den})};
      else                  r = {1'b0, t[ProdW-1:0]};
      return r;
   endfunction

   function automatic logic [DataW:0] finish(input logic [DataW:0] q, input logic big,
                                             input logic neg);
      logic [DataW:0] r;
      if (neg) begin
         if (big || q > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
         else                            r = {1'b0, 32'(-q)};
      end else begin
         if (big || q[DataW] || q[DataW-1]) r = {1'b1, 32'h7fff_ffff};
         else                               r = {1'b0, q[DataW-1:0]};
      end
      return r;
   endfunction

   assign en  = !out_vld_ff || rsp_tready;
   assign pop = en && !q_stat.empty;

   always_comb begin
      logic [ProdW:0] sr, si;
      logic nbr, nbi;
      stg_in[0].it     = pop_item;
      stg_in[0].rem_re = '0;
      stg_in[0].rem_im = '0;
      stg_in[0].q_re   = '0;
      stg_in[0].q_im   = '0;
      stg_in[0].big_re = 1'b0;
      stg_in[0].big_im = 1'b0;
      for (int k = 0; k < DivSteps; k++) begin
         nbr = (k < ProdW) ? stg_ff[k].it.mag_re[(ProdW-1-k) % ProdW] : 1'b0;
         nbi = (k < ProdW) ? stg_ff[k].it.mag_im[(ProdW-1-k) % ProdW] : 1'b0;
         sr  = div_step(stg_ff[k].rem_re, nbr, stg_ff[k].it.den);
         si  = div_step(stg_ff[k].rem_im, nbi, stg_ff[k].it.den);
         stg_in[k+1].it     = stg_ff[k].it;
         stg_in[k+1].rem_re = sr[ProdW-1:0];
         stg_in[k+1].rem_im = si[ProdW-1:0];
         stg_in[k+1].q_re   = {stg_ff[k].q_re[DataW-1:0], sr[ProdW]};
         stg_in[k+1].q_im   = {stg_ff[k].q_im[DataW-1:0], si[ProdW]};
         stg_in[k+1].big_re = stg_ff[k].big_re | stg_ff[k].q_re[DataW];
         stg_in[k+1].big_im = stg_ff[k].big_im | stg_ff[k].q_im[DataW];
      end
   end

   always_comb begin
      fin_re = finish(stg_ff[DivSteps].q_re, stg_ff[DivSteps].big_re,
                      stg_ff[DivSteps].it.neg_re);
      fin_im = finish(stg_ff[DivSteps].q_im, stg_ff[DivSteps].big_im,
                      stg_ff[DivSteps].it.neg_im);
      out_dz_in = 1'b0;
      if (stg_ff[DivSteps].it.op != OP_DIV) begin
         out_re_in = stg_ff[DivSteps].it.fast_re;
         out_im_in = stg_ff[DivSteps].it.fast_im;
         out_ov_in = stg_ff[DivSteps].it.fast_ov;
      end else if (stg_ff[DivSteps].it.dz) begin
         out_re_in = '0;
         out_im_in = '0;
         out_ov_in = 1'b0;
         out_dz_in = 1'b1;
      end else begin
         out_re_in = fin_re[DataW-1:0];
         out_im_in = fin_im[DataW-1:0];
         out_ov_in = fin_re[DataW] | fin_im[DataW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[DivSteps-1:0], pop};
         out_vld_ff <= vld_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DivSteps; k++) stg_ff[k] <= stg_in[k];
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
         out_ov_ff <= out_ov_in;
         out_dz_ff <= out_dz_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_im_ff, out_re_ff};
   assign rsp_tuser  = {out_dz_ff, out_ov_ff};

   // zero divisor always gives a clean zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_dz_ff |-> out_re_ff == '0 && out_im_ff == '0 && !out_ov_ff)
      else $error("div_zero result not zero");

   // stalled divider pipeline holds its occupancy
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("divider pipeline moved while stalled");

   // an item leaving the last divider stage lands in the output register
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[DivSteps] |=> out_vld_ff)
      else $error("result lost at output register");

endmodule
`default_nettype wire

@@ sv/complex_arithmetic_unit_top.sv @@
// top level of the complex arithmetic unit (add, subtract, multiply, divide in Q16.16)
// depends on cau_pkg, cau_front, cau_queue, cau_back
//
// The unit takes one transaction per cycle: operands a and b as signed Q16.16
// complex numbers and an operation (add, subtract, multiply, divide), and returns
// one saturated complex result with an overflow flag and a divide-by-zero flag.
// Results come back in the order the operands went in. Every transaction sees the
// same latency when the output side is not stalled. It passes 3 front stages
// (operand register, six 32x32 products, combine and classify), one queue write,
// a divider load stage and 80 restoring-division stages, then one output register.
// The 80 division steps (64 numerator bits plus 16 fraction bits) set the latency;
// the sustained rate is one transaction per cycle. The front stalls only when the
// queue is full, the back only when the output register is held.
`default_nettype none
module complex_arithmetic_unit_top import cau_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request stream
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [4*DataW-1:0] req_tdata,  // a_re, a_im, b_re, b_im
   input  wire logic [1:0]         req_tuser,  // command
   // response stream
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [2*DataW-1:0]      rsp_tdata,  // res_re, res_im
   output logic [1:0]              rsp_tuser   // overflow, div_zero
);

   // front to queue
   logic      push;
   item_type  push_item;
   // queue to back
   logic      pop;
   item_type  pop_item;
   qstat_type q_stat;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_item  (push_item),
      .q_stat     (q_stat)
   );

   // decouples classification from the divider pipeline
   cau_queue #(.Depth(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_item   (pop_item),
      .q_stat     (q_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// self-checking testbench for complex_arithmetic_unit_top (Q16.16 add, sub, mul, div)
// depends on cau_pkg and the unit's RTL; directed corners, then random operands
// under several sender and receiver idling phases
`default_nettype none
module tb import cau_pkg::*; ();

   typedef struct {
      op_type            op;
      logic signed [31:0] a_re, a_im, b_re, b_im;
   } operands_type;

   typedef struct {
      logic [31:0] re, im;
      logic        ov, dz;
   } complex_res_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;  // a_re, a_im, b_re, b_im
   logic [1:0]    req_tuser = '0;  // command
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [63:0]   rsp_tdata;       // res_re, res_im
   logic [1:0]    rsp_tuser;       // overflow, div_zero
   logic          in_fire = 1'b0;  // request taken at the last rising edge

   operands_type     pending_ops[$];
   complex_res_type  predicted_results[$];
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            mismatches = 0;
   int            n_sent = 0, n_checked = 0;
   int            quiet_cycles = 0;

   complex_arithmetic_unit_top i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // clamp a wide signed value to 32 bits, noting saturation
   function automatic logic [31:0] clamp32(logic signed [65:0] v, inout logic ov);
      if (v > 66'sh7FFFFFFF) begin
         ov = 1'b1;
         return 32'h7FFFFFFF;
      end
      if (v < -66'sh80000000) begin
         ov = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // truncated quotient (sum << 16) / den, saturated
   function automatic logic [31:0] quotient_part(logic signed [65:0] s, logic [63:0] den,
                                                 inout logic ov);
      logic [65:0] mag;
      logic [79:0] quo;
      mag = (s < 0) ? -s : s;
      quo = {mag[63:0], 16'b0} / {16'b0, den};
      if (s < 0) begin
         if (quo > 80'h80000000) begin
            ov = 1'b1;
            return 32'h80000000;
         end
         return -quo[31:0];
      end
      if (quo > 80'h7FFFFFFF) begin
         ov = 1'b1;
         return 32'h7FFFFFFF;
      end
      return quo[31:0];
   endfunction

   function automatic complex_res_type complex_op(operands_type t);
      complex_res_type   r;
      longint            p_rr, p_ii, p_ri, p_ir;
      logic signed [65:0] s_re, s_im;
      logic [63:0]       den;
      r.ov = 1'b0;
      r.dz = 1'b0;
      r.re = '0;
      r.im = '0;
      p_rr = longint'(t.a_re) * longint'(t.b_re);
      p_ii = longint'(t.a_im) * longint'(t.b_im);
      p_ri = longint'(t.a_re) * longint'(t.b_im);
      p_ir = longint'(t.a_im) * longint'(t.b_re);
      case (t.op)
         OP_ADD: begin
            r.re = clamp32(66'(t.a_re) + 66'(t.b_re), r.ov);
            r.im = clamp32(66'(t.a_im) + 66'(t.b_im), r.ov);
         end
         OP_SUB: begin
            r.re = clamp32(66'(t.a_re) - 66'(t.b_re), r.ov);
            r.im = clamp32(66'(t.a_im) - 66'(t.b_im), r.ov);
         end
         OP_MUL: begin
            // exact Q32.32 sums, floor shift back to Q16.16
            s_re = 66'(p_rr) - 66'(p_ii);
            s_im = 66'(p_ri) + 66'(p_ir);
            r.re = clamp32(s_re >>> 16, r.ov);
            r.im = clamp32(s_im >>> 16, r.ov);
         end
         default: begin
            den = 64'(longint'(t.b_re) * longint'(t.b_re))
                + 64'(longint'(t.b_im) * longint'(t.b_im));
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               s_re = 66'(p_rr) + 66'(p_ii);
               s_im = 66'(p_ir) - 66'(p_ri);
               r.re = quotient_part(s_re, den, r.ov);
               r.im = quotient_part(s_im, den, r.ov);
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_part(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(1, 0) ? 32'h7FFFFFFF - $urandom_range(3, 0)
                                        : 32'h80000000 + $urandom_range(3, 0);
         2: return 32'($signed($urandom_range(262144, 0)) - 131072);   // about +-2.0
         default: return 32'($signed($urandom_range(33554432, 0)) - 16777216);
      endcase
   endfunction

   task automatic queue_op(op_type op, logic [31:0] ar, ai, br, bi);
      operands_type t;
      t.op = op;
      t.a_re = ar;
      t.a_im = ai;
      t.b_re = br;
      t.b_im = bi;
      pending_ops.push_back(t);
   endtask

   task automatic queue_random(int count);
      operands_type t;
      int        style;
      repeat (count) begin
         style = $urandom_range(3, 0);
         t.op = op_type'($urandom_range(3, 0));
         t.a_re = rand_part(style);
         t.a_im = rand_part(style);
         t.b_re = rand_part($urandom_range(3, 0));
         t.b_im = ($urandom_range(7, 0) == 0) ? 32'h0 : rand_part($urandom_range(3, 0));
         // occasional zero divisor
         if (t.op == OP_DIV && $urandom_range(15, 0) == 0) begin
            t.b_re = '0;
            t.b_im = '0;
         end
         pending_ops.push_back(t);
      end
   endtask

   // request driver: present the next transaction once the previous one is taken
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || in_fire)) begin
         if (pending_ops.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_ops[0].op;
            req_tdata  <= {pending_ops[0].b_im, pending_ops[0].b_re,
                           pending_ops[0].a_im, pending_ops[0].a_re};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      complex_res_type want;
      int              bad;
      logic            moved;
      bad   = 0;
      moved = 1'b0;
      in_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted_results.push_back(complex_op(pending_ops.pop_front()));
            n_sent <= n_sent + 1;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            n_checked <= n_checked + 1;
            if (predicted_results.size() == 0) begin
               $error("response with no transaction outstanding");
               bad++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_tdata[31:0] !== want.re) begin
                  $error("res_re: expected %h, got %h", want.re, rsp_tdata[31:0]);
                  bad++;
               end
               if (rsp_tdata[63:32] !== want.im) begin
                  $error("res_im: expected %h, got %h", want.im, rsp_tdata[63:32]);
                  bad++;
               end
               if (rsp_tuser[0] !== want.ov) begin
                  $error("overflow: expected %b, got %b", want.ov, rsp_tuser[0]);
                  bad++;
               end
               if (rsp_tuser[1] !== want.dz) begin
                  $error("div_zero: expected %b, got %b", want.dz, rsp_tuser[1]);
                  bad++;
               end
            end
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         mismatches   <= mismatches + bad;
      end
   end

   // watchdog: far beyond pipeline latency plus long stall runs
   always @(posedge clock) begin
      if (quiet_cycles >= 3000) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic drain;
      while (pending_ops.size() > 0 || predicted_results.size() > 0) @(negedge clock);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed corners: extremes, every op, zero divisor, scalar b, rounding signs
      queue_op(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
      queue_op(OP_ADD, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      queue_op(OP_ADD, 32'h00010000, 32'h0, 32'h00020000, 32'h0);
      queue_op(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
      queue_op(OP_SUB, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      queue_op(OP_SUB, 32'hFFFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF);
      queue_op(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      queue_op(OP_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      queue_op(OP_MUL, 32'hFFFFFFFF, 32'h0, 32'h00000001, 32'h0);   // negative tiny, floors
      queue_op(OP_MUL, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001);
      queue_op(OP_MUL, 32'h00018000, 32'hFFFF8000, 32'h00020000, 32'h0);
      queue_op(OP_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0);   // zero divisor
      queue_op(OP_DIV, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
      queue_op(OP_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'h0);
      queue_op(OP_DIV, 32'h80000000, 32'h0, 32'h00010000, 32'h0);
      queue_op(OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      queue_op(OP_DIV, 32'hFFFFFFFF, 32'h00000001, 32'h00030000, 32'hFFFD0000);
      queue_op(OP_DIV, 32'h00010000, 32'h0, 32'h00030000, 32'h0);   // truncates toward 0
      queue_op(OP_DIV, 32'hFFFF0000, 32'h0, 32'h00030000, 32'h0);
      queue_op(OP_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      drain();

      // random phases: free flow, slow sender, slow receiver, both slow
      send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(200); drain();
      send_idle_pct = 78; recv_stall_pct = 0;  queue_random(200); drain();
      send_idle_pct = 0;  recv_stall_pct = 78; queue_random(200); drain();
      send_idle_pct = 13; recv_stall_pct = 13; queue_random(200); drain();

      repeat (150) @(negedge clock);
      $display("covered %0d transactions (add, sub, mul, div with saturating and", n_sent);
      $display("zero-divisor corners) over four idling phases, %0d responses checked",
               n_checked);
      if (mismatches == 0 && predicted_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire
